FILE: rtl/core/ofv_pkg.sv
// ----------------------------------------------------------------------------
// ofv_pkg
// Shared types and constants for the optical flow frame velocity block:
// frame phases, capture offsets, configuration indexes and datapath widths.
// ----------------------------------------------------------------------------
package ofv_pkg;

  // Datapath widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned FLOW_W = 16;
  localparam int unsigned OFS_W  = 11;
  localparam int unsigned HGT_W  = DIST_W + 2;       // distance + offset, signed
  localparam int unsigned PROD_W = FLOW_W + HGT_W;   // full signed product
  localparam int unsigned VEL_W  = 49;
  localparam int unsigned CIDX_W = 2;

  // Framing constants
  localparam logic [BYTE_W-1:0] HDR_BYTE    = 8'hEF;
  localparam logic [BYTE_W-1:0] SKIP_LAST   = 8'd3;   // last of four skipped bytes
  localparam logic [BYTE_W-1:0] MIN_PAYLOAD = 8'd20;

  // Payload byte offsets of the captured fields
  localparam logic [BYTE_W-1:0] IDX_DIST_LO = 8'd4;
  localparam logic [BYTE_W-1:0] IDX_DIST_HI = 8'd7;
  localparam logic [BYTE_W-1:0] IDX_FX_LO   = 8'd12;
  localparam logic [BYTE_W-1:0] IDX_FX_HI   = 8'd13;
  localparam logic [BYTE_W-1:0] IDX_FY_LO   = 8'd14;
  localparam logic [BYTE_W-1:0] IDX_FY_HI   = 8'd15;
  localparam logic [BYTE_W-1:0] IDX_QUAL    = 8'd16;

  // Configuration register indexes and reset values
  localparam logic [CIDX_W-1:0] CFG_HEIGHT_OFFSET = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_QUALITY_THR   = 2'd1;
  localparam logic signed [OFS_W-1:0] OFS_RST     = 11'sd41;
  localparam logic [BYTE_W-1:0]       THR_RST     = 8'd50;

  // Frame parser phases
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SKIP,
    PH_LEN,
    PH_PAYLOAD,
    PH_TRAIL
  } phase_t;

  // Completed frame from the parser
  typedef struct packed {
    logic                     done;
    logic [DIST_W-1:0]        distance;
    logic signed [FLOW_W-1:0] flow_x;
    logic signed [FLOW_W-1:0] flow_y;
    logic [BYTE_W-1:0]        quality;
  } frame_t;

endpackage

FILE: rtl/core/ofv_parser.sv
// ----------------------------------------------------------------------------
// ofv_parser
// Byte-wise frame parser: hunts for the header, skips four bytes, takes the
// payload length, captures distance, flows and quality, drops the trailer.
// ----------------------------------------------------------------------------
module ofv_parser
  import ofv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_acc,
  input  logic [BYTE_W-1:0] rx_byte,
  output frame_t            frame
);

  phase_t                   phase_r, phase_nxt;
  logic [BYTE_W-1:0]        pos_r, pos_nxt;
  logic [BYTE_W-1:0]        len_r, len_nxt;
  logic [DIST_W-1:0]        dist_r, dist_nxt;
  logic signed [FLOW_W-1:0] fx_r, fx_nxt;
  logic signed [FLOW_W-1:0] fy_r, fy_nxt;
  logic [BYTE_W-1:0]        qual_r, qual_nxt;
  logic [BYTE_W-1:0]        pos_inc;

  assign pos_inc = pos_r + 8'd1;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (byte_acc) begin
      unique case (phase_r)
        PH_HUNT:    if (rx_byte == HDR_BYTE) phase_nxt = PH_SKIP;
        PH_SKIP:    if (pos_r == SKIP_LAST) phase_nxt = PH_LEN;
        PH_LEN:     phase_nxt = (rx_byte == '0) ? PH_TRAIL : PH_PAYLOAD;
        PH_PAYLOAD: if (pos_inc >= len_r) phase_nxt = PH_TRAIL;
        PH_TRAIL:   phase_nxt = PH_HUNT;
        default:    phase_nxt = PH_HUNT;
      endcase
    end
  end

  // Position, length and field capture
  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    dist_nxt = dist_r;
    fx_nxt   = fx_r;
    fy_nxt   = fy_r;
    qual_nxt = qual_r;
    if (byte_acc) begin
      unique case (phase_r)
        PH_HUNT:    pos_nxt = '0;
        PH_SKIP:    pos_nxt = (pos_r == SKIP_LAST) ? '0 : pos_inc;
        PH_LEN: begin
          len_nxt = rx_byte;
          pos_nxt = '0;
        end
        PH_PAYLOAD: begin
          pos_nxt = pos_inc;
          case (pos_r) inside
            [IDX_DIST_LO:IDX_DIST_HI]: dist_nxt[pos_r[1:0]*BYTE_W +: BYTE_W] = rx_byte;
            IDX_FX_LO: fx_nxt[7:0]  = rx_byte;
            IDX_FX_HI: fx_nxt[15:8] = rx_byte;
            IDX_FY_LO: fy_nxt[7:0]  = rx_byte;
            IDX_FY_HI: fy_nxt[15:8] = rx_byte;
            IDX_QUAL:  qual_nxt     = rx_byte;
            default: ;
          endcase
        end
        PH_TRAIL:   pos_nxt = '0;
        default:    pos_nxt = '0;
      endcase
    end
  end

  // Flag the trailing byte of a long enough frame
  always_comb begin
    frame.done     = byte_acc && (phase_r == PH_TRAIL) && (len_r >= MIN_PAYLOAD);
    frame.distance = dist_r;
    frame.flow_x   = fx_r;
    frame.flow_y   = fy_r;
    frame.quality  = qual_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      len_r   <= '0;
      dist_r  <= '0;
      fx_r    <= '0;
      fy_r    <= '0;
      qual_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      dist_r  <= dist_nxt;
      fx_r    <= fx_nxt;
      fy_r    <= fy_nxt;
      qual_r  <= qual_nxt;
    end
  end

endmodule

FILE: rtl/core/ofv_vel_pipe.sv
// ----------------------------------------------------------------------------
// ofv_vel_pipe
// Velocity pipeline: height and quality test, two flow by height products,
// then negation, held pair selection and the output register.
// ----------------------------------------------------------------------------
module ofv_vel_pipe
  import ofv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  frame_t                  frame,
  input  logic signed [OFS_W-1:0] height_offset,
  input  logic [BYTE_W-1:0]       quality_thr,
  output logic                    ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VEL_W-1:0] out_vel_x,
  output logic signed [VEL_W-1:0] out_vel_y,
  output logic                    out_fresh,
  output logic [BYTE_W-1:0]       out_quality,
  output logic [DIST_W-1:0]       out_distance_mm
);

  // Stage 1: height, flows, quality test
  logic                     s1_v_r, s1_v_nxt;
  logic signed [HGT_W-1:0]  s1_hgt_r;
  logic signed [FLOW_W-1:0] s1_fx_r, s1_fy_r;
  logic                     s1_fresh_r;
  logic [BYTE_W-1:0]        s1_qual_r;
  logic [DIST_W-1:0]        s1_dist_r;
  // Stage 2: products
  logic                     s2_v_r, s2_v_nxt;
  logic signed [PROD_W-1:0] s2_px_r, s2_py_r;
  logic                     s2_fresh_r;
  logic [BYTE_W-1:0]        s2_qual_r;
  logic [DIST_W-1:0]        s2_dist_r;
  // Output and held pair
  logic                     out_v_r, out_v_nxt;
  logic signed [VEL_W-1:0]  vx_r, vy_r;
  logic                     fresh_r;
  logic [BYTE_W-1:0]        qual_r;
  logic [DIST_W-1:0]        dist_r;
  logic signed [VEL_W-1:0]  held_x_r, held_y_r;

  logic                     out_free, s2_free, s1_free;
  logic                     s1_move, s2_move;
  logic signed [HGT_W-1:0]  hgt_nxt;
  logic signed [PROD_W-1:0] px_nxt, py_nxt;
  logic signed [VEL_W-1:0]  vx_nxt, vy_nxt;

  // Elastic stage control
  assign out_free = !out_v_r || !out_stall;
  assign s2_move  = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_move  = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign ready    = s1_free;

  assign s1_v_nxt  = (s1_v_r && !s1_move) || frame.done;
  assign s2_v_nxt  = (s2_v_r && !s2_move) || s1_move;
  assign out_v_nxt = (out_v_r && !out_free) || s2_move;

  // Height = raw distance + signed offset
  assign hgt_nxt = signed'({2'b00, frame.distance}) + HGT_W'(height_offset);

  // One multiplier per axis
  assign px_nxt = s1_fx_r * s1_hgt_r;
  assign py_nxt = s1_fy_r * s1_hgt_r;

  // Negate y, or fall back to the held pair
  assign vx_nxt = s2_fresh_r ? s2_px_r[VEL_W-1:0] : held_x_r;
  assign vy_nxt = s2_fresh_r ? (VEL_W'(0) - s2_py_r[VEL_W-1:0]) : held_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      held_x_r <= '0;
      held_y_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      if (s2_move && s2_fresh_r) begin
        held_x_r <= vx_nxt;
        held_y_r <= vy_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (frame.done) begin
      s1_hgt_r   <= hgt_nxt;
      s1_fx_r    <= frame.flow_x;
      s1_fy_r    <= frame.flow_y;
      s1_fresh_r <= frame.quality > quality_thr;
      s1_qual_r  <= frame.quality;
      s1_dist_r  <= frame.distance;
    end
    if (s1_move) begin
      s2_px_r    <= px_nxt;
      s2_py_r    <= py_nxt;
      s2_fresh_r <= s1_fresh_r;
      s2_qual_r  <= s1_qual_r;
      s2_dist_r  <= s1_dist_r;
    end
    if (s2_move) begin
      vx_r    <= vx_nxt;
      vy_r    <= vy_nxt;
      fresh_r <= s2_fresh_r;
      qual_r  <= s2_qual_r;
      dist_r  <= s2_dist_r;
    end
  end

  assign out_valid       = out_v_r;
  assign out_vel_x       = vx_r;
  assign out_vel_y       = vy_r;
  assign out_fresh       = fresh_r;
  assign out_quality     = qual_r;
  assign out_distance_mm = dist_r;

endmodule

FILE: rtl/core/optical_flow_frame_velocity.sv
// ----------------------------------------------------------------------------
// optical_flow_frame_velocity
// Decodes optical flow sensor frames from a byte stream and reports velocity
// as flow times height, holding the last good pair on low quality frames.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_stall is low; a new byte is
//   taken while a result waits. Each frame's result passes the height,
//   product and output registers in turn before out_valid rises.
// in_stall rises only when all three result stages are full and out is stalled.
// Reset: synchronous, active low; parser back to header hunt, held pair zero,
//   offset 41 mm, quality threshold 50.
module optical_flow_frame_velocity
  import ofv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [OFS_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [BYTE_W-1:0]       in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VEL_W-1:0] out_vel_x,
  output logic signed [VEL_W-1:0] out_vel_y,
  output logic                    out_fresh,
  output logic [BYTE_W-1:0]       out_quality,
  output logic [DIST_W-1:0]       out_distance_mm
);

  logic signed [OFS_W-1:0] ofs_r, ofs_nxt;
  logic [BYTE_W-1:0]       thr_r, thr_nxt;
  logic                    ready;
  logic                    byte_acc;
  frame_t                  frame;

  // Configuration register decode
  always_comb begin
    ofs_nxt = ofs_r;
    thr_nxt = thr_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HEIGHT_OFFSET: ofs_nxt = signed'(cfg_wdata);
        CFG_QUALITY_THR:   thr_nxt = cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r <= OFS_RST;
      thr_r <= THR_RST;
    end else begin
      ofs_r <= ofs_nxt;
      thr_r <= thr_nxt;
    end
  end

  // Input handshake
  assign in_stall = !ready;
  assign byte_acc = in_valid && ready;

  ofv_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_acc (byte_acc),
    .rx_byte  (in_rx_byte),
    .frame    (frame)
  );

  ofv_vel_pipe u_vel (
    .clk             (clk),
    .rst_n           (rst_n),
    .frame           (frame),
    .height_offset   (ofs_r),
    .quality_thr     (thr_r),
    .ready           (ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_vel_x       (out_vel_x),
    .out_vel_y       (out_vel_y),
    .out_fresh       (out_fresh),
    .out_quality     (out_quality),
    .out_distance_mm (out_distance_mm)
  );

endmodule

FILE: rtl/core/ofv_checker.sv
// ----------------------------------------------------------------------------
// ofv_checker
// Port-level checks for the optical flow frame velocity block, bound to the
// top level.
// ----------------------------------------------------------------------------
module ofv_checker
  import ofv_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VEL_W-1:0] out_vel_x,
  input logic signed [VEL_W-1:0] out_vel_y,
  input logic                    out_fresh
);

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its velocity and freshness
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_vel_x) && $stable(out_vel_y) && $stable(out_fresh))
    else $error("result changed while stalled");

  // Input backpressure only comes from a stalled, full result path
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Reset empties the result path
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind optical_flow_frame_velocity ofv_checker u_ofv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_vel_x (out_vel_x),
  .out_vel_y (out_vel_y),
  .out_fresh (out_fresh)
);

FILE: bench/optical_flow_frame_velocity_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// optical_flow_frame_velocity_tb
// Feeds sensor byte streams into the frame velocity block: a short table of
// hand-built frames first, then random frames, noise and broken frames under
// several register settings. A byte-level tracker of the frame parser works
// out every velocity result, and each result leaving the block is compared
// field by field against the oldest one pending. Both sides idle at random.
// ----------------------------------------------------------------------------
module optical_flow_frame_velocity_tb
  import ofv_pkg::*;
();

  // Register indexes with no register behind them
  localparam logic [CIDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int PLAN_ROWS   = 18;
  localparam int PHASE_BYTES = 200;
  localparam int RAND_PHASES = 6;
  localparam int DRAIN_CYCLES = 12;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

  // One directed step: a whole frame, or a register write (len = index,
  // dist_mm = write data). Expected velocities are typed in only where marked.
  typedef struct {
    row_kind_t          kind;
    logic [7:0]         len;
    logic [31:0]        dist_mm;
    logic [15:0]        fx;
    logic [15:0]        fy;
    logic [7:0]         qual;
    logic [7:0]         pad;
    bit                 typed;
    logic signed [48:0] want_vx;
    logic signed [48:0] want_vy;
    bit                 want_fresh;
  } plan_row_t;

  typedef struct {
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic                    fresh;
    logic [BYTE_W-1:0]       qual;
    logic [DIST_W-1:0]       dist_mm;
  } velocity_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0]       cfg_index = '0;
  logic [OFS_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [BYTE_W-1:0]       in_rx_byte = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VEL_W-1:0] out_vel_x;
  logic signed [VEL_W-1:0] out_vel_y;
  logic                    out_fresh;
  logic [BYTE_W-1:0]       out_quality;
  logic [DIST_W-1:0]       out_distance_mm;

  optical_flow_frame_velocity u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_vel_x       (out_vel_x),
    .out_vel_y       (out_vel_y),
    .out_fresh       (out_fresh),
    .out_quality     (out_quality),
    .out_distance_mm (out_distance_mm)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parser tracker state and its copy of the registers
  phase_t                  trk_phase = PH_HUNT;
  logic [7:0]              trk_pos = '0;
  logic [7:0]              trk_len = '0;
  logic [DIST_W-1:0]       trk_dist = '0;
  logic [FLOW_W-1:0]       trk_fx = '0;
  logic [FLOW_W-1:0]       trk_fy = '0;
  logic [BYTE_W-1:0]       trk_qual = '0;
  logic signed [VEL_W-1:0] held_vx = '0;
  logic signed [VEL_W-1:0] held_vy = '0;
  logic signed [OFS_W-1:0] trk_offset = OFS_RST;
  logic [BYTE_W-1:0]       trk_thr = THR_RST;

  velocity_t pending_velocities[$];
  bit        typed_due = 1'b0;
  velocity_t typed_value;

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  frames_sent = 0;
  int  results_checked = 0;
  int  fresh_results = 0;
  bit  calm = 1'b0;
  int  gap_pct = 20;
  int  stall_pct = 20;
  int  stall_left = 0;
  plan_row_t frame_plan [PLAN_ROWS];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  // Track one accepted byte through the frame parser; push a velocity on the
  // trailing byte of a long enough frame.
  task automatic predict_byte(input logic [7:0] b);
    longint    height;
    longint    flow_x;
    longint    flow_y;
    velocity_t v;
    case (trk_phase)
      PH_HUNT: begin
        if (b == HDR_BYTE) begin
          trk_phase = PH_SKIP;
          trk_pos = '0;
        end
      end
      PH_SKIP: begin
        if (trk_pos == SKIP_LAST) begin
          trk_phase = PH_LEN;
          trk_pos = '0;
        end else begin
          trk_pos = trk_pos + 8'd1;
        end
      end
      PH_LEN: begin
        trk_len = b;
        trk_pos = '0;
        trk_phase = (b == 8'd0) ? PH_TRAIL : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        // capture the fields at their payload offsets
        if (trk_pos >= IDX_DIST_LO && trk_pos <= IDX_DIST_HI)
          trk_dist[8*(trk_pos - IDX_DIST_LO) +: 8] = b;
        else if (trk_pos == IDX_FX_LO) trk_fx[7:0] = b;
        else if (trk_pos == IDX_FX_HI) trk_fx[15:8] = b;
        else if (trk_pos == IDX_FY_LO) trk_fy[7:0] = b;
        else if (trk_pos == IDX_FY_HI) trk_fy[15:8] = b;
        else if (trk_pos == IDX_QUAL) trk_qual = b;
        trk_pos = trk_pos + 8'd1;
        if (trk_pos >= trk_len) trk_phase = PH_TRAIL;
      end
      PH_TRAIL: begin
        trk_phase = PH_HUNT;
        trk_pos = '0;
        if (trk_len >= MIN_PAYLOAD) begin
          height = longint'(trk_dist) + longint'(trk_offset);
          flow_x = $signed(trk_fx);
          flow_y = $signed(trk_fy);
          if (trk_qual > trk_thr) begin
            held_vx = VEL_W'(flow_x * height);
            held_vy = VEL_W'(-(flow_y * height));
            v.fresh = 1'b1;
          end else begin
            v.fresh = 1'b0;
          end
          v.vx = held_vx;
          v.vy = held_vy;
          v.qual = trk_qual;
          v.dist_mm = trk_dist;
          if (typed_due) begin
            pending_velocities.push_back(typed_value);
            typed_due = 1'b0;
          end else begin
            pending_velocities.push_back(v);
          end
        end
      end
      default: begin
        trk_phase = PH_HUNT;
        trk_pos = '0;
      end
    endcase
  endtask

  // Check results, track register writes and accepted bytes at each edge
  always @(posedge clk) begin
    velocity_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_velocities.size() == 0) begin
          report_mismatch("unexpected result, vel_x", out_vel_x, 0);
        end else begin
          w = pending_velocities.pop_front();
          results_checked++;
          if (w.fresh) fresh_results++;
          if (out_vel_x !== w.vx) report_mismatch("vel_x", out_vel_x, w.vx);
          if (out_vel_y !== w.vy) report_mismatch("vel_y", out_vel_y, w.vy);
          if (out_fresh !== w.fresh) report_mismatch("fresh", out_fresh, w.fresh);
          if (out_quality !== w.qual) report_mismatch("quality", out_quality, w.qual);
          if (out_distance_mm !== w.dist_mm)
            report_mismatch("distance_mm", out_distance_mm, w.dist_mm);
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == CFG_HEIGHT_OFFSET) trk_offset = cfg_wdata;
        else if (cfg_index == CFG_QUALITY_THR) trk_thr = cfg_wdata[7:0];
      end
      if (in_valid && !in_stall) predict_byte(in_rx_byte);
    end
  end

  // Random result side stall bursts
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one byte, with an optional idle burst first; returns on a falling
  // edge after the item is taken, valid still high.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Write a register once the block has drained
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [OFS_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_velocities.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Whole frame; non-field bytes are pad, or random when scramble is set
  task automatic send_frame(input logic [7:0] len, input logic [31:0] dist_mm,
                            input logic [15:0] fx, input logic [15:0] fy,
                            input logic [7:0] qual, input logic [7:0] pad,
                            input bit scramble);
    logic [7:0] b;
    frames_sent++;
    send_byte(HDR_BYTE);
    repeat (4) send_byte(scramble ? 8'($urandom_range(0, 255)) : pad);
    send_byte(len);
    for (int i = 0; i < len; i++) begin
      b = scramble ? 8'($urandom_range(0, 255)) : pad;
      if (i >= IDX_DIST_LO && i <= IDX_DIST_HI) b = dist_mm[8*(i - IDX_DIST_LO) +: 8];
      else if (i == IDX_FX_LO) b = fx[7:0];
      else if (i == IDX_FX_HI) b = fx[15:8];
      else if (i == IDX_FY_LO) b = fy[7:0];
      else if (i == IDX_FY_HI) b = fy[15:8];
      else if (i == IDX_QUAL) b = qual;
      send_byte(b);
    end
    send_byte(scramble ? 8'($urandom_range(0, 255)) : pad);
  endtask

  // Random frame, mostly well formed, sometimes noise or cut short
  task automatic send_random_frame();
    int          pick;
    logic [7:0]  len;
    logic [31:0] dist_mm;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // header and a few bytes, then drop the frame
      send_byte(HDR_BYTE);
      repeat ($urandom_range(0, 10)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 18) len = 8'($urandom_range(0, 19));
    else if (pick < 21) len = 8'($urandom_range(100, 255));
    else len = 8'($urandom_range(20, 40));
    case ($urandom_range(0, 5))
      0: dist_mm = 32'd0;
      1: dist_mm = 32'hFFFF_FFFF;
      2, 3: dist_mm = $urandom_range(0, 5000);
      default: dist_mm = $urandom;
    endcase
    send_frame(len, dist_mm, 16'($urandom), 16'($urandom), 8'($urandom_range(0, 255)),
               8'h00, 1'b1);
  endtask

  initial begin
    plan_row_t r;
    int        offsets [RAND_PHASES];
    int        thresholds [RAND_PHASES];
    int        phase_end;

    // kind, len, dist_mm, flow x, flow y, quality, pad, typed, vel x, vel y, fresh
    frame_plan[0]  = '{ROW_FRAME, 8'd0, 32'd0, 16'h0000, 16'h0000, 8'd0, 8'h00,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    frame_plan[1]  = '{ROW_FRAME, 8'd19, 32'd1234, 16'h0005, 16'h0005, 8'd99, 8'hEF,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    // held pair is zero after reset; quality equal to threshold is not fresh
    frame_plan[2]  = '{ROW_FRAME, 8'd20, 32'd1000, 16'h0007, 16'h0007, 8'd50, 8'h00,
                       1'b1, 49'sd0, 49'sd0, 1'b0};
    // distance 0 plus reset offset 41
    frame_plan[3]  = '{ROW_FRAME, 8'd20, 32'd0, 16'h0001, 16'h0001, 8'd51, 8'hFF,
                       1'b1, 49'sd41, -49'sd41, 1'b1};
    frame_plan[4]  = '{ROW_FRAME, 8'd20, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 8'hFF, 8'hEF,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    frame_plan[5]  = '{ROW_FRAME, 8'd20, 32'd0, 16'h0000, 16'h0000, 8'd0, 8'h55,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    frame_plan[6]  = '{ROW_FRAME, 8'd255, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 8'hC8, 8'hAA,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    frame_plan[7]  = '{ROW_CFG, 8'(CFG_HEIGHT_OFFSET), 32'h418, 16'h0, 16'h0, 8'd0, 8'h00,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    frame_plan[8]  = '{ROW_CFG, 8'(CFG_QUALITY_THR), 32'h000, 16'h0, 16'h0, 8'd0, 8'h00,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    // writes to unused indexes must leave both registers alone
    frame_plan[9]  = '{ROW_CFG, 8'(CFG_SPARE_2), 32'h7FF, 16'h0, 16'h0, 8'd0, 8'h00,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    frame_plan[10] = '{ROW_CFG, 8'(CFG_SPARE_3), 32'h7FF, 16'h0, 16'h0, 8'd0, 8'h00,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    // negative height
    frame_plan[11] = '{ROW_FRAME, 8'd20, 32'd5, 16'h0064, 16'hFF9C, 8'd1, 8'h00,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    frame_plan[12] = '{ROW_FRAME, 8'd21, 32'd7, 16'h0003, 16'h0003, 8'd0, 8'h33,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    frame_plan[13] = '{ROW_CFG, 8'(CFG_HEIGHT_OFFSET), 32'h3E8, 16'h0, 16'h0, 8'd0, 8'h00,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    frame_plan[14] = '{ROW_CFG, 8'(CFG_QUALITY_THR), 32'h0FF, 16'h0, 16'h0, 8'd0, 8'h00,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    frame_plan[15] = '{ROW_FRAME, 8'd20, 32'd0, 16'h0001, 16'hFFFF, 8'hFF, 8'h00,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    frame_plan[16] = '{ROW_CFG, 8'(CFG_QUALITY_THR), 32'h0FE, 16'h0, 16'h0, 8'd0, 8'h00,
                       1'b0, 49'sd0, 49'sd0, 1'b0};
    // height is the 1000 mm offset alone
    frame_plan[17] = '{ROW_FRAME, 8'd20, 32'd0, 16'hFFFF, 16'h0001, 8'hFF, 8'h00,
                       1'b1, -49'sd1000, -49'sd1000, 1'b1};

    offsets    = '{-1000, 1000, 0, -1, 0, 0};
    thresholds = '{0, 255, 128, 50, 0, 0};
    offsets[4] = $urandom_range(0, 2000) - 1000;
    offsets[5] = $urandom_range(0, 2000) - 1000;
    thresholds[4] = $urandom_range(0, 255);
    thresholds[5] = $urandom_range(0, 255);

    // hold reset low, then release it
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // walk the directed table
    for (int i = 0; i < PLAN_ROWS; i++) begin
      r = frame_plan[i];
      if (r.kind == ROW_CFG) begin
        write_reg(r.len[CIDX_W-1:0], r.dist_mm[OFS_W-1:0]);
      end else begin
        if (r.typed) begin
          typed_value = '{r.want_vx, r.want_vy, r.want_fresh, r.qual, r.dist_mm};
          typed_due = 1'b1;
        end
        send_byte(~r.pad);
        send_frame(r.len, r.dist_mm, r.fx, r.fy, r.qual, r.pad, 1'b0);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_reg(CFG_HEIGHT_OFFSET, OFS_W'(offsets[p]));
      write_reg(CFG_QUALITY_THR, {3'($urandom_range(0, 7)), 8'(thresholds[p])});
      calm = (p == RAND_PHASES - 1);
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) send_random_frame();
    end

    // drain
    in_valid <= 1'b0;
    while (pending_velocities.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d frames under %0d register settings.",
             bytes_sent, frames_sent, RAND_PHASES + 4);
    $display("Checked %0d velocity results, %0d fresh and %0d held; %0d mismatches.",
             results_checked, fresh_results, results_checked - fresh_results, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still pending.", pending_velocities.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
